// ===== rtl/skpl_pkg.sv =====
// skpl_pkg: shared types, constants and codes for the sorted key priority list.
// Used by every module under rtl/; depends on nothing.
package skpl_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int KEY_WIDTH  = 32;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [ITEM_WIDTH-1:0]       item_t;
    typedef logic [COUNT_W-1:0]          count_t;

    localparam key_t MIN_KEY = -32'sd2147483646;
    localparam key_t MAX_KEY = 32'sd2147483646;
    localparam key_t ERR_KEY = -32'sd2147483647;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_EMPTY = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_DELETE = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CMP   = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
        logic     found;
        key_t     key;
        item_t    item;
    } cell_ctl_t;

    // what the chain reports back
    typedef struct packed {
        logic  found;
        key_t  head_key;
        item_t head_item;
        key_t  sel_key;
        item_t sel_item;
    } chain_res_t;

endpackage

// ===== rtl/skpl_cell.sv =====
// skpl_cell: one list slot holding a key and an item, with its compare flags.
// Depends on skpl_pkg; reads the broadcast control and its two neighbors.
module skpl_cell (
    input  logic               clk,
    input  skpl_pkg::cell_ctl_t ctl,
    input  logic               occ,
    input  logic               left_ge,
    input  logic               left_at,
    input  skpl_pkg::key_t     left_key,
    input  skpl_pkg::item_t    left_item,
    input  skpl_pkg::key_t     right_key,
    input  skpl_pkg::item_t    right_item,
    output skpl_pkg::key_t     key,
    output skpl_pkg::item_t    item,
    output logic               ge,
    output logic               at,
    output logic               sel
);
    import skpl_pkg::*;

    key_t  key_reg,  key_next;
    item_t item_reg, item_next;
    logic  ge_reg,   ge_next;
    logic  eq_reg,   eq_next;

    assign at = ge_reg | ~occ;   // new word belongs here or further left

    always_comb
    begin
        key_next  = key_reg;
        item_next = item_reg;
        ge_next   = ge_reg;
        eq_next   = eq_reg;
        if (ctl.cmp_en)
        begin
            ge_next = occ && (key_reg >= ctl.key);
            eq_next = (key_reg == ctl.key);
        end
        case (ctl.op)
            OP_INSERT:
            begin
                if (left_at)
                begin
                    key_next  = left_key;
                    item_next = left_item;
                end
                else if (at)
                begin
                    key_next  = ctl.key;
                    item_next = ctl.item;
                end
            end
            OP_POP:
            begin
                key_next  = right_key;
                item_next = right_item;
            end
            OP_DELETE:
            begin
                if (ctl.found && ge_reg)
                begin
                    key_next  = right_key;
                    item_next = right_item;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        item_reg <= item_next;
        ge_reg   <= ge_next;
        eq_reg   <= eq_next;
    end

    assign key  = key_reg;
    assign item = item_reg;
    assign ge   = ge_reg;
    assign sel  = ge_reg & ~left_ge & eq_reg;

endmodule

// ===== rtl/skpl_chain.sv =====
// skpl_chain: the row of CAPACITY cells with neighbor wiring and result pick.
// Depends on skpl_pkg and skpl_cell.
module skpl_chain (
    input  logic                clk,
    input  skpl_pkg::cell_ctl_t ctl,
    input  skpl_pkg::count_t    count,
    output skpl_pkg::chain_res_t res
);
    import skpl_pkg::*;

    key_t  keys  [CAPACITY];
    item_t items [CAPACITY];
    logic [CAPACITY-1:0] ge_v, at_v, sel_v, occ_v;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t  lk, rk;
        item_t li, ri;
        logic  lg, la;

        assign occ_v[i] = (count > COUNT_W'(i));

        if (i == 0)
        begin : g_head
            assign lk = ctl.key;
            assign li = ctl.item;
            assign lg = 1'b0;
            assign la = 1'b0;
        end
        else
        begin : g_body
            assign lk = keys[i-1];
            assign li = items[i-1];
            assign lg = ge_v[i-1];
            assign la = at_v[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rk = keys[i];
            assign ri = items[i];
        end
        else
        begin : g_mid
            assign rk = keys[i+1];
            assign ri = items[i+1];
        end

        skpl_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occ        (occ_v[i]),
            .left_ge    (lg),
            .left_at    (la),
            .left_key   (lk),
            .left_item  (li),
            .right_key  (rk),
            .right_item (ri),
            .key        (keys[i]),
            .item       (items[i]),
            .ge         (ge_v[i]),
            .at         (at_v[i]),
            .sel        (sel_v[i])
        );
    end

    // at most one cell flags sel, so an AND-OR pick is enough
    always_comb
    begin
        res.found     = |sel_v;
        res.head_key  = keys[0];
        res.head_item = items[0];
        res.sel_key   = '0;
        res.sel_item  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            res.sel_key  = res.sel_key  | (keys[i]  & {KEY_WIDTH{sel_v[i]}});
            res.sel_item = res.sel_item | (items[i] & {ITEM_WIDTH{sel_v[i]}});
        end
    end

endmodule

// ===== rtl/sorted_key_priority_list_unit.sv =====
// Sorted key priority list: CAPACITY (key, item) slots kept in ascending key order.
// Each command passes the compare state, then the apply state, which waits while a result is still pending.
// One command at a time: a new one is taken only once the compare-then-shift pass of the cell row is done.
// The result register frees the input side: a new word is taken while a result waits.
// Reset (rst_n low, async): list empty, count zero, no result pending; slot contents
// stay undefined and are never read before written.
module sorted_key_priority_list_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic signed [31:0]    key_in,
    input  logic [31:0]           item_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic signed [31:0]    key_out,
    output logic [31:0]           item_out,
    output logic [6:0]            entry_count,
    output logic                  list_empty
);
    import skpl_pkg::*;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    logic    out_valid_reg, out_valid_next;

    // captured command word
    cmd_t    cmd_reg;
    key_t    key_reg;
    item_t   item_reg;

    // result word
    status_t status_reg, status_next;
    key_t    kout_reg,   kout_next;
    item_t   iout_reg,   iout_next;

    cell_ctl_t  ctl;
    chain_res_t res;

    logic key_ok;
    logic slot_free;
    logic in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign key_ok    = (key_reg >= MIN_KEY) && (key_reg <= MAX_KEY);
    assign slot_free = !out_valid_reg || out_ready;

    skpl_chain u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .count (count_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd_t'(cmd);
            key_reg  <= key_in;
            item_reg <= item_in;
        end
        status_reg <= status_next;
        kout_reg   <= kout_next;
        iout_reg   <= iout_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        kout_next      = kout_reg;
        iout_next      = iout_reg;
        ctl.cmp_en     = 1'b0;
        ctl.op         = OP_HOLD;
        ctl.found      = res.found;
        ctl.key        = key_reg;
        ctl.item       = item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // every cell compares its key against the command key
                ctl.cmp_en = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = STS_OK;
                    kout_next      = '0;
                    iout_next      = '0;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!key_ok)
                                status_next = STS_RANGE;
                            else if (count_reg == COUNT_W'(CAPACITY))
                                status_next = STS_FULL;
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                                kout_next   = ERR_KEY;
                            end
                            else
                            begin
                                kout_next  = res.head_key;
                                iout_next  = res.head_item;
                                ctl.op     = OP_POP;
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!key_ok)
                            begin
                                status_next = STS_RANGE;
                                kout_next   = ERR_KEY;
                            end
                            else if (!res.found)
                            begin
                                status_next = STS_EMPTY;
                                kout_next   = ERR_KEY;
                            end
                            else
                            begin
                                // cells from the first match onward close the gap
                                kout_next  = res.sel_key;
                                iout_next  = res.sel_item;
                                ctl.op     = OP_DELETE;
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        default:
                        begin
                            // undefined command: no change, zero result
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count as it stands after the command, held alongside the result word
    logic [COUNT_W-1:0] count_at_out_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_APPLY && slot_free)
            count_at_out_reg <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign key_out     = kout_reg;
    assign item_out    = iout_reg;
    assign entry_count = 7'(count_at_out_reg);
    assign list_empty  = (count_at_out_reg == '0);

endmodule

// ===== rtl/skpl_checker.sv =====
// skpl_checker: port-level assertions for sorted_key_priority_list_unit, plus bind.
// Depends on skpl_pkg and the top level's port list.
module skpl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [31:0] key_out,
    input logic [31:0]        item_out,
    input logic [6:0]         entry_count,
    input logic               list_empty
);
    import skpl_pkg::*;

    // one word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before accept");

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (list_empty == (entry_count == 7'd0)))
        else $error("list_empty disagrees with entry_count");

    // count never exceeds capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= 7'(CAPACITY)))
        else $error("entry_count above capacity");

    // a failed command carries no item
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STS_OK) |-> (item_out == 32'd0))
        else $error("item returned on failed command");

endmodule

bind sorted_key_priority_list_unit skpl_checker u_skpl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .key_out     (key_out),
    .item_out    (item_out),
    .entry_count (entry_count),
    .list_empty  (list_empty)
);
